// File: rtl/core/ppmhp_pkg.sv
// types and constants shared by the p6 header parser
package ppmhp_pkg;

	// width of the parsed numbers; they saturate at the all-ones value
	localparam int unsigned DIM_BITS = 16;

	localparam logic [1:0] ST_HEADER = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_PIXEL  = 2'd2;
	localparam logic [1:0] ST_ERROR  = 2'd3;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [DIM_BITS-1:0] MAXVAL_LIMIT = DIM_BITS'(255);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} byte_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [7:0]          pixel_byte;
		logic [DIM_BITS-1:0] image_width;
		logic [DIM_BITS-1:0] image_height;
		logic [DIM_BITS-1:0] max_value;
	} result_t;

endpackage

// File: rtl/core/ppm_p6_header_parser.sv
// raw colour ppm (p6) header parser, one file byte per request
//
// Each accepted request carries one byte of a P6 file and produces exactly one
// result: status (header byte, header complete, pixel byte or error), the byte
// echoed when it is pixel data, and the width, height and maximum value parsed
// so far. The header is the magic "P6" followed by three decimal numbers, each
// preceded by any run of space, tab, LF, CR or '#' comments running to LF.
// Numbers saturate at 65535; a maximum above 255 is an error, and exactly one
// whitespace byte must follow the maximum. Errors stick until a request with
// start_of_file set, which restarts parsing on that very byte. Throughput is one
// byte per clock: the parse state and the result register are both updated in
// the cycle a request is taken, so the result is presented in the following cycle.
// A pending result does not block the input as long as result_ready is high;
// with result_ready low the block holds one result and stops taking requests.
module ppm_p6_header_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  ppmhp_pkg::byte_req_t byte_req,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ppmhp_pkg::result_t   result
);
	import ppmhp_pkg::*;

	// parse phases
	localparam logic [3:0] PH_MAGIC_P = 4'd0;
	localparam logic [3:0] PH_MAGIC_6 = 4'd1;
	localparam logic [3:0] PH_SEP_W   = 4'd2;
	localparam logic [3:0] PH_NUM_W   = 4'd3;
	localparam logic [3:0] PH_SEP_H   = 4'd4;
	localparam logic [3:0] PH_NUM_H   = 4'd5;
	localparam logic [3:0] PH_SEP_M   = 4'd6;
	localparam logic [3:0] PH_NUM_M   = 4'd7;
	localparam logic [3:0] PH_PIXELS  = 4'd8;
	localparam logic [3:0] PH_ERROR   = 4'd9;

	localparam logic [DIM_BITS+3:0] DIM_MAX_EXT = {4'd0, {DIM_BITS{1'b1}}};

	logic [3:0]          phase_q;
	logic                in_comment_q;
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [DIM_BITS-1:0] maxval_q;

	// state as seen by the current byte (start of file clears it)
	logic [3:0]          phase_cur;
	logic                comment_cur;
	logic [DIM_BITS-1:0] width_cur;
	logic [DIM_BITS-1:0] height_cur;
	logic [DIM_BITS-1:0] maxval_cur;

	logic [3:0]          phase_nxt;
	logic                comment_nxt;
	logic [DIM_BITS-1:0] width_nxt;
	logic [DIM_BITS-1:0] height_nxt;
	logic [DIM_BITS-1:0] maxval_nxt;
	logic [1:0]          status_nxt;
	logic [7:0]          pixel_nxt;

	logic [7:0]          b;
	logic                is_ws;
	logic                is_digit;
	logic [DIM_BITS-1:0] digit;
	logic [DIM_BITS-1:0] acc_sel;
	logic [DIM_BITS+3:0] acc_ext;
	logic [DIM_BITS-1:0] acc_new;
	logic                accept;

	assign accept     = byte_valid && byte_ready;
	// result register parts the two sides: a taken result frees the slot at once
	assign byte_ready = !result_valid || result_ready;

	assign b        = byte_req.data_byte;
	assign is_ws    = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign digit    = DIM_BITS'(b - CH_ZERO);

	always_comb begin
		if (byte_req.start_of_file) begin
			phase_cur   = PH_MAGIC_P;
			comment_cur = 1'b0;
			width_cur   = '0;
			height_cur  = '0;
			maxval_cur  = '0;
		end else begin
			phase_cur   = phase_q;
			comment_cur = in_comment_q;
			width_cur   = width_q;
			height_cur  = height_q;
			maxval_cur  = maxval_q;
		end
	end

	// one shared decimal accumulator: acc * 10 + digit, saturating
	always_comb begin
		unique case (phase_cur)
			PH_NUM_W: acc_sel = width_cur;
			PH_NUM_H: acc_sel = height_cur;
			default:  acc_sel = maxval_cur;
		endcase
		acc_ext = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + {4'd0, digit};
		acc_new = (acc_ext > DIM_MAX_EXT) ? {DIM_BITS{1'b1}} : acc_ext[DIM_BITS-1:0];
	end

	// next state and result for the current byte
	always_comb begin
		phase_nxt   = phase_cur;
		comment_nxt = comment_cur;
		width_nxt   = width_cur;
		height_nxt  = height_cur;
		maxval_nxt  = maxval_cur;
		status_nxt  = ST_HEADER;
		pixel_nxt   = '0;
		unique case (phase_cur)
			PH_MAGIC_P: phase_nxt = (b == CH_P) ? PH_MAGIC_6 : PH_ERROR;
			PH_MAGIC_6: phase_nxt = (b == CH_SIX) ? PH_SEP_W : PH_ERROR;
			PH_SEP_W, PH_SEP_H, PH_SEP_M: begin
				priority if (comment_cur) begin
					if (b == CH_LF) begin
						comment_nxt = 1'b0;
					end
				end else if (b == CH_HASH) begin
					comment_nxt = 1'b1;
				end else if (is_ws) begin
					phase_nxt = phase_cur;
				end else if (is_digit) begin
					phase_nxt = phase_cur + 4'd1;
					unique case (phase_cur)
						PH_SEP_W: width_nxt  = digit;
						PH_SEP_H: height_nxt = digit;
						default:  maxval_nxt = digit;
					endcase
				end else begin
					phase_nxt = PH_ERROR;
				end
			end
			PH_NUM_W, PH_NUM_H: begin
				priority if (is_digit) begin
					if (phase_cur == PH_NUM_W) begin
						width_nxt = acc_new;
					end else begin
						height_nxt = acc_new;
					end
				end else if (is_ws) begin
					phase_nxt = phase_cur + 4'd1;
				end else if (b == CH_HASH) begin
					// comment may directly follow the width or height
					comment_nxt = 1'b1;
					phase_nxt   = phase_cur + 4'd1;
				end else begin
					phase_nxt = PH_ERROR;
				end
			end
			PH_NUM_M: begin
				priority if (is_digit) begin
					maxval_nxt = acc_new;
				end else if ((maxval_cur > MAXVAL_LIMIT) || !is_ws) begin
					phase_nxt = PH_ERROR;
				end else begin
					phase_nxt  = PH_PIXELS;
					status_nxt = ST_DONE;
				end
			end
			PH_PIXELS: begin
				status_nxt = ST_PIXEL;
				pixel_nxt  = b;
			end
			default: phase_nxt = PH_ERROR;
		endcase
		if (phase_nxt == PH_ERROR) begin
			status_nxt = ST_ERROR;
			pixel_nxt  = '0;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_MAGIC_P;
			in_comment_q <= 1'b0;
			width_q      <= '0;
			height_q     <= '0;
			maxval_q     <= '0;
		end else if (accept) begin
			phase_q      <= phase_nxt;
			in_comment_q <= comment_nxt;
			width_q      <= width_nxt;
			height_q     <= height_nxt;
			maxval_q     <= maxval_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (accept) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result.status       <= status_nxt;
			result.pixel_byte   <= pixel_nxt;
			result.image_width  <= width_nxt;
			result.image_height <= height_nxt;
			result.max_value    <= maxval_nxt;
		end
	end

	// every taken request yields a result on the next cycle
	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("request taken without a result");

	// header complete leaves the parser in pixel phase
	a_done_to_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_DONE) |-> (phase_q == PH_PIXELS))
		else $error("header complete but parser not in pixel phase");

	// error status matches the sticky error phase
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_ERROR) |-> (phase_q == PH_ERROR))
		else $error("error status without error phase");

	// pixel byte is zero unless the result is pixel data
	a_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != ST_PIXEL) |-> (result.pixel_byte == 8'd0))
		else $error("pixel byte set on a non-pixel result");

endmodule
